### rtl/ptw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the two-level page table walker.
// No dependencies; the walker and the bench import this package.
package ptw_pkg;

    // Sizes of the tables and the slot pool
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_SLOTS   = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int FREE_W        = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W         = 1 + SLOT_W;
    localparam int TBL_AW        = SLOT_W + IDX_W;
    localparam int TBL_DEPTH     = (1 << SLOT_W) * TABLE_ENTRIES;

    // Address and entry layout
    localparam int ADDR_W  = 32;
    localparam int FLAG_W  = 12;
    localparam int FRAME_W = ADDR_W - FLAG_W;
    localparam int DIR_LSB = 22;
    localparam int TBL_LSB = 12;

    localparam logic [FLAG_W-1:0] NEW_TABLE_FLAGS_RST = 12'h007;

    // Operation codes carried in the mode field
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_MAP    = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic [FLAG_W-1:0] entry_flags;
    } walk_req_t;

    typedef struct packed {
        logic              mapped;
        logic [ADDR_W-1:0] phys_frame;
        logic              status;
    } walk_rsp_t;

    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } dir_entry_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIR,
        S_TBL,
        S_CLR,
        S_OUT
    } walk_state_t;

endpackage

### rtl/two_level_page_table_walker.sv
`timescale 1ns / 1ps
// Two-level page table walker: directory RAM, table pool RAM and the walk sequencer.
// Depends on ptw_pkg and ptw_ram.
//
//  channel  signals                    word
//  req      req_valid req_ready req    walk_req_t (mode, virt_addr, phys_addr, entry_flags)
//  rsp      rsp_valid rsp_ready rsp    walk_rsp_t (mapped, phys_frame, status)
//  cfg      cfg_valid cfg_ready cfg_data   new_table_flags, always ready
//
// A lookup reads the directory, then the table. A map into a present directory entry
// writes the table entry and answers from the directory step; a dropped map answers there too.
// A map that allocates a table sweeps the new table, one entry a cycle through the
// single table write port, then answers.
// After reset the directory is cleared one entry a cycle, and req_ready stays low until
// every entry is cleared. One word is in flight at a time; a full response register
// holds the sequencer in its last step.
module two_level_page_table_walker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ptw_pkg::walk_req_t         req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output ptw_pkg::walk_rsp_t         rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ptw_pkg::FLAG_W-1:0] cfg_data
);

    import ptw_pkg::*;

    walk_state_t       state_reg, state_next;
    walk_req_t         item_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FREE_W-1:0] free_reg, free_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FLAG_W-1:0] flags_reg;
    walk_rsp_t         res_reg, res_next;
    walk_rsp_t         rsp_reg, rsp_load_val;
    logic              rsp_valid_reg;
    logic              rsp_load;

    logic              dir_we, dir_re;
    logic [IDX_W-1:0]  dir_waddr;
    dir_entry_t        dir_wdata, dir_rd;
    logic [DIR_W-1:0]  dir_rdata;
    logic              tbl_we, tbl_re;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
    logic [ADDR_W-1:0] tbl_wdata, tbl_rdata;

    logic              accept, out_free, idx_last, pool_empty;
    logic [IDX_W-1:0]  dir_idx, tbl_idx;
    logic [ADDR_W-1:0] new_entry;
    walk_rsp_t         map_res;

    assign accept     = req_valid && req_ready;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign idx_last   = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign pool_empty = (free_reg == FREE_W'(TABLE_SLOTS));
    assign dir_idx    = item_reg.virt_addr[DIR_LSB +: IDX_W];
    assign tbl_idx    = item_reg.virt_addr[TBL_LSB +: IDX_W];
    assign new_entry  = {item_reg.phys_addr[ADDR_W-1:FLAG_W], item_reg.entry_flags};
    assign dir_rd     = dir_entry_t'(dir_rdata);

    // Result of a completed map as seen by a following walk
    always_comb
    begin
        map_res.mapped     = item_reg.entry_flags[0];
        map_res.phys_frame = item_reg.entry_flags[0] ?
                             {item_reg.phys_addr[ADDR_W-1:FLAG_W], FLAG_W'(0)} : '0;
        map_res.status     = 1'b0;
    end

    ptw_ram #(
        .WIDTH (DIR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (req.virt_addr[DIR_LSB +: IDX_W]),
        .rdata (dir_rdata)
    );

    ptw_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                if (item_reg.mode == MODE_LOOKUP && dir_rd.present)
                begin
                    state_next = S_TBL;
                end
                else if (item_reg.mode == MODE_MAP && !dir_rd.present && !pool_empty)
                begin
                    state_next = S_CLR;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TBL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (idx_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Memory controls, counters and result
    always_comb
    begin
        req_ready    = 1'b0;
        dir_re       = 1'b0;
        dir_we       = 1'b0;
        dir_waddr    = dir_idx;
        dir_wdata    = '0;
        tbl_we       = 1'b0;
        tbl_re       = 1'b0;
        tbl_waddr    = {dir_rd.slot, tbl_idx};
        tbl_wdata    = new_entry;
        tbl_raddr    = {dir_rd.slot, tbl_idx};
        idx_next     = idx_reg;
        free_next    = free_reg;
        slot_next    = slot_reg;
        res_next     = res_reg;
        rsp_load     = 1'b0;
        rsp_load_val = res_reg;
        unique case (state_reg)
            S_INIT:
            begin
                // clear the directory one entry a cycle
                dir_we    = 1'b1;
                dir_waddr = idx_reg;
                idx_next  = idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                dir_re    = req_valid;
            end
            S_DIR:
            begin
                if (item_reg.mode == MODE_LOOKUP)
                begin
                    if (dir_rd.present)
                    begin
                        tbl_re = 1'b1;
                    end
                    else
                    begin
                        rsp_load     = out_free;
                        rsp_load_val = '0;
                    end
                end
                else if (dir_rd.present)
                begin
                    // write the page entry into the existing table
                    tbl_we       = out_free;
                    rsp_load     = out_free;
                    rsp_load_val = map_res;
                end
                else if (pool_empty)
                begin
                    rsp_load            = out_free;
                    rsp_load_val        = '0;
                    rsp_load_val.status = 1'b1;
                end
                else
                begin
                    // allocate the next slot and mark the directory entry
                    dir_we            = 1'b1;
                    dir_wdata.present = flags_reg[0];
                    dir_wdata.slot    = free_reg[SLOT_W-1:0];
                    slot_next         = free_reg[SLOT_W-1:0];
                    free_next         = free_reg + 1'b1;
                    idx_next          = '0;
                    res_next          = flags_reg[0] ? map_res : '0;
                end
            end
            S_TBL:
            begin
                rsp_load                = out_free;
                rsp_load_val.mapped     = tbl_rdata[0];
                rsp_load_val.phys_frame = tbl_rdata[0] ?
                                          {tbl_rdata[ADDR_W-1:FLAG_W], FLAG_W'(0)} : '0;
                rsp_load_val.status     = 1'b0;
            end
            S_CLR:
            begin
                // sweep the new table, dropping the page entry in on the way
                tbl_we    = 1'b1;
                tbl_waddr = {slot_reg, idx_reg};
                tbl_wdata = (idx_reg == tbl_idx) ? new_entry : '0;
                idx_next  = idx_reg + 1'b1;
            end
            S_OUT:
            begin
                rsp_load = out_free;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            free_reg      <= '0;
            flags_reg     <= NEW_TABLE_FLAGS_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            free_reg  <= free_next;
            if (cfg_valid && cfg_ready)
            begin
                flags_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_load_val;
        end
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The pool counter never runs past the number of slots
    assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(TABLE_SLOTS))
        else $error("slot counter overflow");

    // An accepted word always starts with the directory read
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DIR)
        else $error("walk did not start after accept");

    // An allocation in the directory step always leads into the table sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (dir_we && state_reg == S_DIR) |=> (state_reg == S_CLR && idx_reg == '0))
        else $error("allocation without table sweep");

    // A dropped map never reports a mapped page
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (!rsp.mapped && rsp.phys_frame == '0))
        else $error("dropped map reports a translation");

    // The pool only grows while a table is allocated
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != $past(free_reg)) |-> state_reg == S_CLR)
        else $error("slot counter moved outside allocation");

endmodule

### rtl/ptw_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold the last word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for two_level_page_table_walker: a scoreboard class predicts each response.
// Depends on ptw_pkg and the walker RTL; drives request, response and table-flags channels.
module tb_top;
    import ptw_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 32;
    localparam int PHASE_WORDS    = 175;

    // Predicts walker responses from its own copy of directory, tables and slot counter
    class page_walk_scoreboard;
        dir_entry_t         dir_q [TABLE_ENTRIES];
        logic [ADDR_W-1:0]  tables [TABLE_SLOTS][TABLE_ENTRIES];
        int unsigned        slots_used;
        logic [FLAG_W-1:0]  table_flags;
        walk_rsp_t          expected_q [$];
        int                 mismatches;
        int                 checked;
        int                 lookups;
        int                 maps;
        int                 allocs;
        int                 drops;

        function new();
            foreach (dir_q[i]) dir_q[i] = '0;
            slots_used  = 0;
            table_flags = NEW_TABLE_FLAGS_RST;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply an accepted request word and queue the response it should produce
        function void note_request(walk_req_t w);
            logic [IDX_W-1:0]  di;
            logic [IDX_W-1:0]  ti;
            dir_entry_t        d;
            logic [ADDR_W-1:0] entry;
            walk_rsp_t         want;
            bit                drop;
            di   = w.virt_addr[ADDR_W-1:DIR_LSB];
            ti   = w.virt_addr[DIR_LSB-1:TBL_LSB];
            drop = 1'b0;
            if (w.mode == MODE_MAP) begin
                maps++;
                d = dir_q[di];
                // Allocate and clear a fresh table when the directory entry is absent and a slot is free
                if (!d.present) begin
                    if (slots_used >= TABLE_SLOTS) begin
                        drop = 1'b1;
                        drops++;
                    end
                    else begin
                        d.slot = SLOT_W'(slots_used);
                        slots_used++;
                        allocs++;
                        for (int i = 0; i < TABLE_ENTRIES; i++) tables[d.slot][i] = '0;
                        d.present = table_flags[0];
                        dir_q[di] = d;
                    end
                end
                if (!drop) tables[d.slot][ti] = {w.phys_addr[ADDR_W-1:TBL_LSB], w.entry_flags};
            end
            else begin
                lookups++;
            end
            // Walk both levels after the update
            d = dir_q[di];
            entry = d.present ? tables[d.slot][ti] : '0;
            want.mapped     = entry[0];
            want.phys_frame = entry[0] ? {entry[ADDR_W-1:TBL_LSB], {FLAG_W{1'b0}}} : '0;
            want.status     = drop;
            expected_q.push_back(want);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH %s", msg);
        endfunction

        // Compare an accepted response word with the oldest prediction
        function void check_response(walk_rsp_t got);
            walk_rsp_t want;
            if (expected_q.size() == 0) begin
                note_mismatch($sformatf("unexpected response mapped=%0b frame=%h status=%0b",
                                        got.mapped, got.phys_frame, got.status));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.mapped !== want.mapped || got.phys_frame !== want.phys_frame ||
                got.status !== want.status)
                note_mismatch($sformatf({"response %0d: expected mapped=%0b frame=%h status=%0b,",
                                         " got mapped=%0b frame=%h status=%0b"},
                                        checked, want.mapped, want.phys_frame, want.status,
                                        got.mapped, got.phys_frame, got.status));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    walk_req_t         req;
    logic              rsp_valid;
    logic              rsp_ready;
    walk_rsp_t         rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [FLAG_W-1:0] cfg_data;

    page_walk_scoreboard sb;
    walk_req_t           req_q [$];
    bit                  req_busy;
    int                  send_idle;
    int                  rsp_stall;
    logic [IDX_W-1:0]    hot_dirs [8];
    logic [IDX_W-1:0]    hot_tbls [16];
    logic [FLAG_W-1:0]   phase_flags [4];

    two_level_page_table_walker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function void queue_word(logic m, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] pa,
                             logic [FLAG_W-1:0] fl);
        walk_req_t w;
        w.mode        = m;
        w.virt_addr   = va;
        w.phys_addr   = pa;
        w.entry_flags = fl;
        req_q.push_back(w);
    endfunction

    // Mostly hit a few hot directories and table indexes so maps and lookups meet
    function automatic walk_req_t random_word();
        walk_req_t        w;
        logic [IDX_W-1:0] di;
        logic [IDX_W-1:0] ti;
        w.mode = $urandom_range(0, 1) ? MODE_MAP : MODE_LOOKUP;
        di = ($urandom_range(0, 99) < 85) ? hot_dirs[$urandom_range(0, 7)] : IDX_W'($urandom);
        ti = ($urandom_range(0, 99) < 70) ? hot_tbls[$urandom_range(0, 15)] : IDX_W'($urandom);
        w.virt_addr   = {di, ti, FLAG_W'($urandom)};
        w.phys_addr   = $urandom;
        w.entry_flags = FLAG_W'($urandom);
        if ($urandom_range(0, 99) < 10)
            w.entry_flags = '0;
        else if ($urandom_range(0, 99) < 75)
            w.entry_flags[0] = 1'b1;
        return w;
    endfunction

    // Hold until every queued word is accepted and answered, then let the block settle
    task wait_drained();
        while (req_q.size() != 0 || req_busy || sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_table_flags(logic [FLAG_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.table_flags = value;
    endtask

    // Request driver: present queued words, idle at random between them
    initial
    begin
        walk_req_t w;
        req_valid <= 1'b0;
        req       <= '0;
        req_busy  = 1'b0;
        @(posedge clk);
        forever
        begin
            if (req_q.size() == 0) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
            else begin
                w = req_q.pop_front();
                req_busy = 1'b1;
                while ($urandom_range(0, 99) < send_idle) begin
                    req_valid <= 1'b0;
                    @(posedge clk);
                end
                req       <= w;
                req_valid <= 1'b1;
                @(posedge clk);
                while (!req_ready) @(posedge clk);
                sb.note_request(w);
                req_busy = 1'b0;
            end
        end
    end

    // Response monitor: check accepted words, stall at random
    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready) sb.check_response(rsp);
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall);
        end
    end

    // Watchdog: end the run when no channel moves a word for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        send_idle = 0;
        rsp_stall = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Lookups on an empty directory, then maps at the address extremes
        queue_word(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000);
        queue_word(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        queue_word(MODE_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        queue_word(MODE_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 12'h000);
        queue_word(MODE_MAP,    32'h003F_F000, 32'h1234_5000, 12'h001);
        queue_word(MODE_LOOKUP, 32'h003F_FABC, 32'h0000_0000, 12'h000);
        // Unmap keeps the frame bits but clears present
        queue_word(MODE_MAP,    32'h003F_F123, 32'hABCD_E000, 12'h000);
        queue_word(MODE_LOOKUP, 32'h003F_F000, 32'h0000_0000, 12'h000);
        queue_word(MODE_MAP,    32'hFFFF_FFFF, 32'h0000_0000, 12'h001);
        queue_word(MODE_MAP,    32'hFFC0_0000, 32'hFFFF_F000, 12'hFFE);
        queue_word(MODE_LOOKUP, 32'hFFC0_0000, 32'h0000_0000, 12'h000);
        queue_word(MODE_LOOKUP, 32'hFFFF_F000, 32'h0000_0000, 12'h000);

        // New tables without present: slot is used, directory stays absent
        write_table_flags(12'h000);
        queue_word(MODE_MAP,    32'h1230_0000, 32'h5555_5000, 12'hFFF);
        queue_word(MODE_LOOKUP, 32'h1230_0000, 32'h0000_0000, 12'h000);
        queue_word(MODE_MAP,    32'h1230_0000, 32'hAAAA_A000, 12'h001);

        write_table_flags(12'hFFF);
        queue_word(MODE_MAP,    32'h1230_0000, 32'hAAAA_AFFF, 12'h001);
        queue_word(MODE_LOOKUP, 32'h1230_0000, 32'h0000_0000, 12'h000);
        queue_word(MODE_LOOKUP, 32'h1230_1000, 32'h0000_0000, 12'h000);
        queue_word(MODE_MAP,    32'h1230_1000, 32'h0000_0000, 12'h000);

        // Hot sets for the random part, seeded with the directed directories and fixed patterns
        hot_dirs[0] = 10'h000;
        hot_dirs[1] = 10'h3FF;
        hot_dirs[2] = 10'h048;
        hot_dirs[3] = 10'h155;
        hot_dirs[4] = 10'h2AA;
        for (int i = 5; i < 8; i++) hot_dirs[i] = IDX_W'($urandom);
        hot_tbls[0] = 10'h000;
        hot_tbls[1] = 10'h3FF;
        for (int i = 2; i < 16; i++) hot_tbls[i] = IDX_W'($urandom);

        phase_flags[0] = 12'hFFF;
        phase_flags[1] = FLAG_W'($urandom_range(0, 4095));
        phase_flags[2] = 12'h001;
        phase_flags[3] = NEW_TABLE_FLAGS_RST;

        // Random phases: no idling, sender idle, receiver stall, both light
        for (int p = 0; p < 4; p++)
        begin
            write_table_flags(phase_flags[p]);
            send_idle = (p == 1) ? 88 : (p == 3) ? 13 : 0;
            rsp_stall = (p == 2) ? 88 : (p == 3) ? 13 : 0;
            repeat (PHASE_WORDS) req_q.push_back(random_word());
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d lookups and %0d maps; %0d tables allocated, %0d maps dropped",
                 sb.lookups, sb.maps, sb.allocs, sb.drops);
        $display("Checked %0d responses: %0d mismatches, %0d responses missing",
                 sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
